// ----- rtl/core/vebc_pkg.sv -----
// shared types, constants and helpers for the voronoi edge box clipper
// no dependencies
package vebc_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_ADDR_W    = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_MIN = 8'd0,
    CFG_X_MAX = 8'd1,
    CFG_Y_MIN = 8'd2,
    CFG_Y_MAX = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                     xm;
    logic                     rej;
    logic signed [DATA_W-1:0] u1;
    logic signed [DATA_W-1:0] u2;
    logic signed [DATA_W-1:0] f1;
    logic signed [DATA_W-1:0] f2;
    logic                     clip1;
    logic                     clip2;
  } ctx_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7fff_ffff;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/vebc_front.sv -----
// front pipeline: endpoint order, window clamp, line products, dependent clip
// depends on vebc_pkg
module vebc_front #(
  parameter int FracBits = vebc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 in_valid_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   coef_a_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   coef_b_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   coef_c_i,
  input  logic                                 has_first_end_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   first_end_x_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   first_end_y_i,
  input  logic                                 has_second_end_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   second_end_x_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   second_end_y_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   x_min_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   x_max_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   y_min_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]   y_max_i,
  output logic                                 valid_o,
  output vebc_pkg::ctx_t                       ctx_o,
  output logic signed [vebc_pkg::DATA_W:0]     num1_o,
  output logic signed [vebc_pkg::DATA_W:0]     num2_o,
  output logic signed [vebc_pkg::DATA_W-1:0]   den_o
);
  import vebc_pkg::*;

  localparam logic signed [DATA_W-1:0] One = DATA_W'(64'sd1 <<< FracBits);

  // stage a
  logic                     va_q, xm_a_q, rej_a_q;
  logic signed [DATA_W-1:0] k_a_q, c_a_q, u1_a_q, u2_a_q, dmin_a_q, dmax_a_q;
  logic                     xm_d, swap, h1s, h2s, rej_d;
  logic signed [DATA_W-1:0] p1, p2, imin, imax, u1_d, u2_d;

  always_comb begin
    xm_d = (coef_a_i == One);
    swap = xm_d && !coef_b_i[DATA_W-1];
    h1s  = swap ? has_second_end_i : has_first_end_i;
    h2s  = swap ? has_first_end_i : has_second_end_i;
    if (xm_d) begin
      p1 = swap ? second_end_y_i : first_end_y_i;
      p2 = swap ? first_end_y_i : second_end_y_i;
      imin = y_min_i;
      imax = y_max_i;
    end else begin
      p1 = first_end_x_i;
      p2 = second_end_x_i;
      imin = x_min_i;
      imax = x_max_i;
    end
    u1_d  = (h1s && p1 > imin) ? p1 : imin;
    u2_d  = (h2s && p2 < imax) ? p2 : imax;
    rej_d = (u1_d > imax) || (u2_d < imin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_a_q   <= xm_d;
      rej_a_q  <= rej_d;
      k_a_q    <= xm_d ? coef_b_i : coef_a_i;
      c_a_q    <= coef_c_i;
      u1_a_q   <= u1_d;
      u2_a_q   <= u2_d;
      dmin_a_q <= xm_d ? x_min_i : y_min_i;
      dmax_a_q <= xm_d ? x_max_i : y_max_i;
    end
  end

  // stage b: products
  logic                     vb_q, xm_b_q, rej_b_q;
  logic signed [DATA_W-1:0] k_b_q, c_b_q, u1_b_q, u2_b_q, dmin_b_q, dmax_b_q;
  logic signed [63:0]       pr1_b_q, pr2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_b_q   <= xm_a_q;
      rej_b_q  <= rej_a_q;
      k_b_q    <= k_a_q;
      c_b_q    <= c_a_q;
      u1_b_q   <= u1_a_q;
      u2_b_q   <= u2_a_q;
      dmin_b_q <= dmin_a_q;
      dmax_b_q <= dmax_a_q;
      pr1_b_q  <= 64'(k_a_q) * 64'(u1_a_q);
      pr2_b_q  <= 64'(k_a_q) * 64'(u2_a_q);
    end
  end

  // stage c: scale, saturate, subtract from c
  logic                     vc_q, xm_c_q, rej_c_q;
  logic signed [DATA_W-1:0] k_c_q, c_c_q, u1_c_q, u2_c_q, dmin_c_q, dmax_c_q;
  logic signed [DATA_W-1:0] d1_c_q, d2_c_q;
  logic signed [DATA_W-1:0] m1, m2;

  always_comb begin
    m1 = sat32(pr1_b_q >>> FracBits);
    m2 = sat32(pr2_b_q >>> FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_c_q   <= xm_b_q;
      rej_c_q  <= rej_b_q;
      k_c_q    <= k_b_q;
      c_c_q    <= c_b_q;
      u1_c_q   <= u1_b_q;
      u2_c_q   <= u2_b_q;
      dmin_c_q <= dmin_b_q;
      dmax_c_q <= dmax_b_q;
      d1_c_q   <= sat32(64'(c_b_q) - 64'(m1));
      d2_c_q   <= sat32(64'(c_b_q) - 64'(m2));
    end
  end

  // stage d: reject test and dependent clip
  logic                     vd_q;
  ctx_t                     ctx_q, ctx_d;
  logic signed [DATA_W:0]   n1_q, n2_q;
  logic signed [DATA_W-1:0] k_d_q, t1, t2;

  always_comb begin
    t1 = (d1_c_q > dmax_c_q) ? dmax_c_q : d1_c_q;
    t2 = (d2_c_q > dmax_c_q) ? dmax_c_q : d2_c_q;
    ctx_d.xm    = xm_c_q;
    ctx_d.rej   = rej_c_q ||
                  (d1_c_q > dmax_c_q && d2_c_q > dmax_c_q) ||
                  (d1_c_q < dmin_c_q && d2_c_q < dmin_c_q);
    ctx_d.u1    = u1_c_q;
    ctx_d.u2    = u2_c_q;
    ctx_d.f1    = (t1 < dmin_c_q) ? dmin_c_q : t1;
    ctx_d.f2    = (t2 < dmin_c_q) ? dmin_c_q : t2;
    ctx_d.clip1 = (d1_c_q > dmax_c_q) || (t1 < dmin_c_q);
    ctx_d.clip2 = (d2_c_q > dmax_c_q) || (t2 < dmin_c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= ctx_d;
      k_d_q <= k_c_q;
      n1_q  <= (DATA_W+1)'(c_c_q) - (DATA_W+1)'(ctx_d.f1);
      n2_q  <= (DATA_W+1)'(c_c_q) - (DATA_W+1)'(ctx_d.f2);
    end
  end

  assign valid_o = vd_q;
  assign ctx_o   = ctx_q;
  assign num1_o  = n1_q;
  assign num2_o  = n2_q;
  assign den_o   = k_d_q;

endmodule

// ----- rtl/core/vebc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturating result
// depends on vebc_pkg
module vebc_div #(
  parameter int FracBits = vebc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [vebc_pkg::DATA_W:0]   num_i,
  input  logic signed [vebc_pkg::DATA_W-1:0] den_i,
  output logic signed [vebc_pkg::DATA_W-1:0] quo_o
);
  import vebc_pkg::*;

  localparam int Uw = DATA_W + FracBits;

  logic [Uw-1:0]     w_q   [0:Uw];
  logic [DATA_W-1:0] r_q   [0:Uw];
  logic [DATA_W-1:0] d_q   [0:Uw];
  logic              neg_q [0:Uw];
  logic              dz_q  [0:Uw];
  logic              np_q  [0:Uw];
  logic              nn_q  [0:Uw];

  logic [DATA_W:0] an, ad;

  always_comb begin
    an = num_i[DATA_W] ? -num_i : num_i;
    ad = den_i[DATA_W-1] ? -(DATA_W+1)'(den_i) : (DATA_W+1)'(den_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0]   <= {an[DATA_W-1:0], {FracBits{1'b0}}};
      r_q[0]   <= '0;
      d_q[0]   <= ad[DATA_W-1:0];
      neg_q[0] <= num_i[DATA_W] != den_i[DATA_W-1];
      dz_q[0]  <= (den_i == '0);
      np_q[0]  <= !num_i[DATA_W] && (num_i != '0);
      nn_q[0]  <= num_i[DATA_W];
    end
  end

  for (genvar k = 1; k <= Uw; k++) begin : g_step
    logic [DATA_W:0] sh, df;
    logic            ge;
    always_comb begin
      sh = {r_q[k-1], w_q[k-1][Uw-1]};
      ge = sh >= {1'b0, d_q[k-1]};
      df = sh - {1'b0, d_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[k]   <= {w_q[k-1][Uw-2:0], ge};
        r_q[k]   <= ge ? df[DATA_W-1:0] : sh[DATA_W-1:0];
        d_q[k]   <= d_q[k-1];
        neg_q[k] <= neg_q[k-1];
        dz_q[k]  <= dz_q[k-1];
        np_q[k]  <= np_q[k-1];
        nn_q[k]  <= nn_q[k-1];
      end
    end
  end

  localparam logic [Uw-1:0] PosLim = Uw'(64'h7fff_ffff);
  localparam logic [Uw-1:0] NegLim = Uw'(64'h8000_0000);

  always_comb begin
    if (dz_q[Uw]) begin
      if (np_q[Uw]) begin
        quo_o = 32'sh7fff_ffff;
      end else if (nn_q[Uw]) begin
        quo_o = 32'sh8000_0000;
      end else begin
        quo_o = '0;
      end
    end else if (!neg_q[Uw]) begin
      quo_o = (w_q[Uw] > PosLim) ? 32'sh7fff_ffff : $signed(w_q[Uw][DATA_W-1:0]);
    end else begin
      quo_o = (w_q[Uw] > NegLim) ? 32'sh8000_0000 : -$signed(w_q[Uw][DATA_W-1:0]);
    end
  end

endmodule

// ----- rtl/core/voronoi_edge_box_clip.sv -----
// top level: window registers, front pipeline, two dividers, context delay line
// depends on vebc_pkg, vebc_front, vebc_div
//
// channel  | handshake             | payload
// cfg      | cfg_valid_i/ready_o   | cfg_addr_i, cfg_data_i
// in       | in_valid_i/ready_o    | coef_*, has_*_end, *_end_x/y
// out      | out_valid_o/ready_i   | seg_valid, start_x/y, stop_x/y
//
// one edge per cycle while the output is not stalled; the divider resolves
// one quotient bit per stage
// a stalled output freezes the whole pipeline in place
// reset clears valid bits and loads the unit window
module voronoi_edge_box_clip #(
  parameter int FracBits = vebc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [vebc_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [vebc_pkg::DATA_W-1:0]            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [vebc_pkg::DATA_W-1:0]     coef_a_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     coef_b_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     coef_c_i,
  input  logic                                   has_first_end_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     first_end_x_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     first_end_y_i,
  input  logic                                   has_second_end_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     second_end_x_i,
  input  logic signed [vebc_pkg::DATA_W-1:0]     second_end_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   seg_valid_o,
  output logic signed [vebc_pkg::DATA_W-1:0]     start_x_o,
  output logic signed [vebc_pkg::DATA_W-1:0]     start_y_o,
  output logic signed [vebc_pkg::DATA_W-1:0]     stop_x_o,
  output logic signed [vebc_pkg::DATA_W-1:0]     stop_y_o
);
  import vebc_pkg::*;

  localparam int DivLat = DATA_W + FracBits + 1;
  localparam logic signed [DATA_W-1:0] One = DATA_W'(64'sd1 <<< FracBits);

  logic signed [DATA_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= '0;
      x_max_q <= One;
      y_min_q <= '0;
      y_max_q <= One;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_X_MIN: x_min_q <= cfg_data_i;
        CFG_X_MAX: x_max_q <= cfg_data_i;
        CFG_Y_MIN: y_min_q <= cfg_data_i;
        CFG_Y_MAX: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q, adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  logic                     f_valid;
  ctx_t                     f_ctx;
  logic signed [DATA_W:0]   f_n1, f_n2;
  logic signed [DATA_W-1:0] f_den, q1, q2;

  vebc_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .en_i(adv),
    .in_valid_i(in_valid_i && in_ready_o),
    .coef_a_i, .coef_b_i, .coef_c_i,
    .has_first_end_i, .first_end_x_i, .first_end_y_i,
    .has_second_end_i, .second_end_x_i, .second_end_y_i,
    .x_min_i(x_min_q), .x_max_i(x_max_q), .y_min_i(y_min_q), .y_max_i(y_max_q),
    .valid_o(f_valid), .ctx_o(f_ctx), .num1_o(f_n1), .num2_o(f_n2), .den_o(f_den)
  );

  vebc_div #(.FracBits(FracBits)) u_div1 (
    .clk_i, .en_i(adv), .num_i(f_n1), .den_i(f_den), .quo_o(q1)
  );

  vebc_div #(.FracBits(FracBits)) u_div2 (
    .clk_i, .en_i(adv), .num_i(f_n2), .den_i(f_den), .quo_o(q2)
  );

  ctx_t dl_q [0:DivLat-1];
  logic dlv_q [0:DivLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLat; k++) begin
        dlv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      dlv_q[0] <= f_valid;
      for (int k = 1; k < DivLat; k++) begin
        dlv_q[k] <= dlv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= f_ctx;
      for (int k = 1; k < DivLat; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  ctx_t                     cx;
  logic signed [DATA_W-1:0] i1, i2;
  logic                     seg_q;
  logic signed [DATA_W-1:0] sx_q, sy_q, ex_q, ey_q;

  always_comb begin
    cx = dl_q[DivLat-1];
    i1 = cx.clip1 ? q1 : cx.u1;
    i2 = cx.clip2 ? q2 : cx.u2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dlv_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_q <= !cx.rej;
      if (cx.rej) begin
        sx_q <= '0;
        sy_q <= '0;
        ex_q <= '0;
        ey_q <= '0;
      end else if (cx.xm) begin
        sx_q <= cx.f1;
        sy_q <= i1;
        ex_q <= cx.f2;
        ey_q <= i2;
      end else begin
        sx_q <= i1;
        sy_q <= cx.f1;
        ex_q <= i2;
        ey_q <= cx.f2;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_valid_o = seg_q;
  assign start_x_o   = sx_q;
  assign start_y_o   = sy_q;
  assign stop_x_o    = ex_q;
  assign stop_y_o    = ey_q;

  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seg_valid_o |->
      start_x_o == '0 && start_y_o == '0 && stop_x_o == '0 && stop_y_o == '0)
    else $error("rejected edge with nonzero coordinates");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(start_x_o) &&
      $stable(stop_y_o) && $stable(seg_valid_o))
    else $error("stalled result changed");

  a_tail_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dlv_q[DivLat-1] |=> out_valid_o)
    else $error("pipeline tail item lost");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for voronoi_edge_box_clip: random and directed edges, window rewrites
// depends on vebc_pkg and the voronoi_edge_box_clip rtl
`timescale 1ns / 1ps

module tb_top;
  import vebc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 8'd9;
  localparam int LIMIT = 600000;
  localparam int DRAIN = 80;

  typedef struct {
    logic signed [31:0] a, b, c;
    bit h0;
    logic signed [31:0] x0, y0;
    bit h1;
    logic signed [31:0] x1, y1;
  } edge_req_t;

  typedef struct {
    bit ok;
    logic signed [31:0] sx, sy, ex, ey;
  } seg_t;

  class clip_scoreboard;
    longint wx_lo, wx_hi, wy_lo, wy_hi;
    seg_t segs_q[$];
    int errors;

    function new();
      wx_lo = 0; wx_hi = ONE; wy_lo = 0; wy_hi = ONE;
      errors = 0;
    endfunction

    function void set_window(logic [CFG_ADDR_W-1:0] idx, logic signed [31:0] d);
      case (idx)
        CFG_X_MIN: wx_lo = d;
        CFG_X_MAX: wx_hi = d;
        CFG_Y_MIN: wy_lo = d;
        CFG_Y_MAX: wy_hi = d;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(SMAX)) return SMAX;
      if (v < longint'(SMIN)) return SMIN;
      return v;
    endfunction

    function longint fx_prod(longint p, longint q);
      longint pr;
      pr = p * q;
      return clamp32(pr >>> FRAC);
    endfunction

    function longint fx_quot(longint num, longint den);
      bit neg;
      longint unsigned un, ud, qt;
      if (den == 0) return (num > 0) ? SMAX : (num < 0) ? SMIN : 0;
      neg = (num < 0) != (den < 0);
      un = longint'(num < 0 ? -num : num) << FRAC;
      ud = den < 0 ? -den : den;
      qt = un / ud;
      if (!neg) return (qt > 64'd2147483647) ? SMAX : longint'(qt);
      if (qt > 64'd2147483648) return SMIN;
      return -longint'(qt);
    endfunction

    function void note_request(edge_req_t r);
      longint a, b, c, p1x, p1y, p2x, p2y, u1, u2, v1, v2;
      bit xm, h1, h2, ok;
      seg_t s;
      a = r.a; b = r.b; c = r.c;
      xm = (r.a == ONE);
      ok = 1;
      if (xm && b >= 0) begin
        h1 = r.h1; p1x = r.x1; p1y = r.y1; h2 = r.h0; p2x = r.x0; p2y = r.y0;
      end else begin
        h1 = r.h0; p1x = r.x0; p1y = r.y0; h2 = r.h1; p2x = r.x1; p2y = r.y1;
      end
      if (xm) begin
        v1 = (h1 && p1y > wy_lo) ? p1y : wy_lo;
        v2 = (h2 && p2y < wy_hi) ? p2y : wy_hi;
        u1 = 0; u2 = 0;
        if (v1 > wy_hi || v2 < wy_lo) ok = 0;
        else begin
          u1 = clamp32(c - fx_prod(b, v1));
          u2 = clamp32(c - fx_prod(b, v2));
          if ((u1 > wx_hi && u2 > wx_hi) || (u1 < wx_lo && u2 < wx_lo)) ok = 0;
          else begin
            if (u1 > wx_hi) begin u1 = wx_hi; v1 = fx_quot(c - u1, b); end
            if (u1 < wx_lo) begin u1 = wx_lo; v1 = fx_quot(c - u1, b); end
            if (u2 > wx_hi) begin u2 = wx_hi; v2 = fx_quot(c - u2, b); end
            if (u2 < wx_lo) begin u2 = wx_lo; v2 = fx_quot(c - u2, b); end
          end
        end
      end else begin
        u1 = (h1 && p1x > wx_lo) ? p1x : wx_lo;
        u2 = (h2 && p2x < wx_hi) ? p2x : wx_hi;
        v1 = 0; v2 = 0;
        if (u1 > wx_hi || u2 < wx_lo) ok = 0;
        else begin
          v1 = clamp32(c - fx_prod(a, u1));
          v2 = clamp32(c - fx_prod(a, u2));
          if ((v1 > wy_hi && v2 > wy_hi) || (v1 < wy_lo && v2 < wy_lo)) ok = 0;
          else begin
            if (v1 > wy_hi) begin v1 = wy_hi; u1 = fx_quot(c - v1, a); end
            if (v1 < wy_lo) begin v1 = wy_lo; u1 = fx_quot(c - v1, a); end
            if (v2 > wy_hi) begin v2 = wy_hi; u2 = fx_quot(c - v2, a); end
            if (v2 < wy_lo) begin v2 = wy_lo; u2 = fx_quot(c - v2, a); end
          end
        end
      end
      s.ok = ok;
      s.sx = ok ? u1[31:0] : 0;
      s.sy = ok ? v1[31:0] : 0;
      s.ex = ok ? u2[31:0] : 0;
      s.ey = ok ? v2[31:0] : 0;
      segs_q.push_back(s);
    endfunction

    function void cmp(string nm, logic signed [31:0] e, logic signed [31:0] g);
      if (e !== g) begin
        $display("%0t %s expected %0d got %0d", $time, nm, e, g);
        errors++;
      end
    endfunction

    function void check_segment(seg_t g);
      seg_t e;
      if (segs_q.size() == 0) begin
        $display("%0t unexpected segment, valid %0d", $time, g.ok);
        errors++;
        return;
      end
      e = segs_q.pop_front();
      cmp("seg_valid", e.ok, g.ok);
      cmp("start_x", e.sx, g.sx);
      cmp("start_y", e.sy, g.sy);
      cmp("stop_x", e.ex, g.ex);
      cmp("stop_y", e.ey, g.ey);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [31:0] coef_a_i = 0, coef_b_i = 0, coef_c_i = 0;
  logic has_first_end_i = 0, has_second_end_i = 0;
  logic signed [31:0] first_end_x_i = 0, first_end_y_i = 0;
  logic signed [31:0] second_end_x_i = 0, second_end_y_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic seg_valid_o;
  logic signed [31:0] start_x_o, start_y_o, stop_x_o, stop_y_o;

  voronoi_edge_box_clip dut (.*);

  clip_scoreboard sb = new();
  int cycles = 0;
  int accepted = 0;
  int burst_left = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn from four modes, one long hold-off
  int rx_mode = 0;
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk_i) begin
    if (cycles % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (!held && accepted >= 400) begin
      held = 1;
      hold_left = 500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= (cycles % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    seg_t g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      g.ok = seg_valid_o;
      g.sx = start_x_o; g.sy = start_y_o; g.ex = stop_x_o; g.ey = stop_y_o;
      sb.check_segment(g);
    end
  end

  task automatic send_edge(edge_req_t r);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1;
    coef_a_i <= r.a; coef_b_i <= r.b; coef_c_i <= r.c;
    has_first_end_i <= r.h0; first_end_x_i <= r.x0; first_end_y_i <= r.y0;
    has_second_end_i <= r.h1; second_end_x_i <= r.x1; second_end_y_i <= r.y1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    accepted++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    burst_left = 0;
    while (sb.segs_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_window(logic [CFG_ADDR_W-1:0] idx, logic signed [31:0] d);
    cfg_valid_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_box(logic signed [31:0] xl, xh, yl, yh);
    write_window(CFG_X_MIN, xl);
    write_window(CFG_X_MAX, xh);
    write_window(CFG_Y_MIN, yl);
    write_window(CFG_Y_MAX, yh);
  endtask

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 11))
      0: return SMIN;
      1: return SMAX;
      2: return 0;
      3, 4: return $urandom;
      5: return $urandom_range(0, 8) * 32'sd16384;
      default: return $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
    endcase
  endfunction

  function automatic edge_req_t rand_edge();
    edge_req_t r;
    r.a = ($urandom_range(0, 1) == 0) ? ONE : pick_val();
    r.b = pick_val(); r.c = pick_val();
    r.h0 = $urandom_range(0, 1); r.x0 = pick_val(); r.y0 = pick_val();
    r.h1 = $urandom_range(0, 1); r.x1 = pick_val(); r.y1 = pick_val();
    return r;
  endfunction

  task automatic send_fixed(logic signed [31:0] a, b, c, bit h0,
                            logic signed [31:0] x0, y0, bit h1,
                            logic signed [31:0] x1, y1);
    edge_req_t r;
    r.a = a; r.b = b; r.c = c;
    r.h0 = h0; r.x0 = x0; r.y0 = y0;
    r.h1 = h1; r.x1 = x1; r.y1 = y1;
    send_edge(r);
  endtask

  task automatic run_random(int n);
    repeat (n) send_edge(rand_edge());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset window, directed edges
    send_fixed(ONE, 0, 32768, 0, 0, 0, 0, 0, 0);
    send_fixed(ONE, 32768, 32768, 1, 0, 16384, 1, 0, 49152);
    send_fixed(ONE, -32768, 32768, 1, 0, -65536, 1, 0, 131072);
    send_fixed(ONE, 131072, 65536, 0, 0, 0, 0, 0, 0);
    send_fixed(ONE, -131072, 0, 0, 0, 0, 0, 0, 0);
    send_fixed(0, ONE, 32768, 0, 0, 0, 0, 0, 0);
    send_fixed(-65536, ONE, 32768, 1, 16384, 0, 1, 49152, 0);
    send_fixed(131072, ONE, 65536, 0, 0, 0, 0, 0, 0);
    send_fixed(ONE, 0, 131072, 0, 0, 0, 0, 0, 0);
    send_fixed(0, ONE, -65536, 0, 0, 0, 0, 0, 0);
    send_fixed(ONE, 0, 32768, 1, 0, 196608, 1, 0, 262144);
    send_fixed(0, ONE, 32768, 1, -196608, 0, 1, -131072, 0);
    send_fixed(SMIN, SMAX, SMIN, 1, SMIN, SMAX, 1, SMAX, SMIN);
    send_fixed(SMAX, SMIN, SMAX, 1, SMAX, SMIN, 1, SMIN, SMAX);
    send_fixed(ONE, SMAX, SMAX, 1, SMIN, SMIN, 1, SMAX, SMAX);
    send_fixed(ONE, SMIN, SMIN, 0, SMAX, SMAX, 0, SMIN, SMIN);
    send_fixed(32'sh0000_0001, 0, 0, 1, 0, 0, 1, 0, 0);
    send_fixed(-32'sd1, -32'sd1, -32'sd1, 1, -32'sd1, -32'sd1, 1, -32'sd1, -32'sd1);
    run_random(200);

    drain();
    set_box(SMIN, SMAX, SMIN, SMAX);
    run_random(200);

    drain();
    set_box(ONE, 0, ONE, 0);
    run_random(200);

    drain();
    set_box(-32'sd65536, 32'sd131072, -32'sd32768, 32'sd98304);
    write_window(CFG_UNUSED, 32'sd12345);
    run_random(200);

    drain();
    set_box($urandom, $urandom, $urandom, $urandom);
    run_random(150);

    drain();
    set_box(32'sd16384, 32'sd16385, -32'sd65536, 32'sd65536);
    run_random(150);

    drain();
    set_box(0, ONE, 0, ONE);
    run_random(100);

    drain();
    if (sb.errors == 0 && sb.segs_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/vebc_pkg.sv
rtl/core/vebc_front.sv
rtl/core/vebc_div.sv
rtl/core/voronoi_edge_box_clip.sv
bench/tb_top.sv
